>>> design/lanc_pkg.sv
package lanc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 15;
  localparam int STEP_SHIFT = 14;
  localparam int Q_SHIFT    = 15;

  localparam logic [STEP_W-1:0] STEP_RESET = 15'd3280;

  // controller -> datapath
  typedef struct packed {
    logic load_in;   // latch input beat, write reference into history
    logic start;     // rewind tap and history pointers
    logic issue;     // read one tap pair this cycle
    logic upd;       // pipeline runs weight update instead of filter
    logic est_load;  // form estimate and error from accumulator
    logic finish;    // load output register, advance mode and position
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } sts_t;

endpackage

>>> design/lanc_ram.sv
module lanc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/lanc_ctrl.sv
module lanc_ctrl #(
  parameter int TAPS = 15
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lanc_pkg::sts_t sts_i,
  output lanc_pkg::cmd_t cmd_o
);

  localparam int CW = $clog2(TAPS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIR,
    ST_EST,
    ST_UPD,
    ST_FIN
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q;
  logic          issuing;

  assign issuing    = cnt_q < CW'(TAPS);
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_in = in_valid_i;
        cmd_o.start   = in_valid_i;
      end
      ST_FIR: begin
        cmd_o.issue = issuing;
      end
      ST_EST: begin
        cmd_o.est_load = 1'b1;
        cmd_o.start    = 1'b1;
      end
      ST_UPD: begin
        cmd_o.issue = issuing;
        cmd_o.upd   = 1'b1;
      end
      ST_FIN: begin
        cmd_o.finish = !sts_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      if (cmd_o.start) begin
        cnt_q <= '0;
      end else if (cmd_o.issue) begin
        cnt_q <= cnt_q + CW'(1);
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_FIR;
        end
        ST_FIR: begin
          if (!issuing && !sts_i.pipe_busy) state_q <= ST_EST;
        end
        ST_EST: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (!issuing && !sts_i.pipe_busy) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!sts_i.out_busy) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_second_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on consecutive cycles");

  a_est_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EST |-> !sts_i.pipe_busy)
    else $error("estimate formed while filter pipeline still busy");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !sts_i.pipe_busy)
    else $error("pipeline busy while idle");

  a_ready_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> $past(cmd_o.finish))
    else $error("ready returned without delivering a result");

endmodule

>>> design/lanc_datapath.sv
module lanc_datapath #(
  parameter int TAPS = 15
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lanc_pkg::cmd_t                        cmd_i,
  output lanc_pkg::sts_t                        sts_o,
  input  logic                                  cfg_valid_i,
  input  logic        [lanc_pkg::STEP_W-1:0]    cfg_data_i,
  input  logic signed [lanc_pkg::SAMPLE_W-1:0]  primary_i,
  input  logic signed [lanc_pkg::SAMPLE_W-1:0]  reference_i,
  input  logic                                  button_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [lanc_pkg::SAMPLE_W-1:0]  out_sample_o,
  output logic signed [lanc_pkg::SAMPLE_W-1:0]  error_sample_o,
  output logic signed [lanc_pkg::SAMPLE_W-1:0]  estimate_sample_o,
  output logic                                  cancel_mode_o
);

  localparam int SW    = lanc_pkg::SAMPLE_W;
  localparam int AW    = $clog2(TAPS);
  localparam int PW    = 2 * SW;
  localparam int ACC_W = PW + $clog2(TAPS) + 1;
  localparam int SH_W  = ACC_W - lanc_pkg::Q_SHIFT;
  localparam int T1_W  = PW - lanc_pkg::STEP_SHIFT;
  localparam int P2_W  = SW + T1_W;

  // control state
  logic [lanc_pkg::STEP_W-1:0] step_q;
  logic [AW-1:0]               pos_q;
  logic [AW-1:0]               tap_q;
  logic [AW-1:0]               idx_q;
  logic [TAPS-1:0]             hv_q;
  logic [TAPS-1:0]             wv_q;
  logic                        v1_q, v2_q, v3_q;
  logic                        flag_q, prev_q;
  logic                        ovalid_q;

  // payload
  logic signed [SW-1:0]    d_q;
  logic                    btn_q;
  logic                    wv1_q, hv1_q;
  logic [AW-1:0]           a1_q, a2_q, a3_q;
  logic signed [SW-1:0]    w2_q, w3_q;
  logic signed [PW-1:0]    p1_q;
  logic signed [P2_W-1:0]  p2_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [SW-1:0]    est_q, err_q;
  logic signed [SW-1:0]    oout_q, oerr_q, oest_q;
  logic                    omode_q;

  logic [SW-1:0]             w_rdata, x_rdata;
  logic signed [SW-1:0]      w1, x1;
  logic signed [SW:0]        ma, mb;
  logic signed [2*SW+1:0]    mul_a;
  logic signed [T1_W-1:0]    t1;
  logic signed [P2_W-1:0]    mul_b;
  logic signed [SW-1:0]      w_new;
  logic signed [ACC_W-1:0]   rnd;
  logic signed [SH_W-1:0]    sh;
  logic [SH_W-SW:0]          sh_hi;
  logic signed [SW-1:0]      est_d, err_d;
  logic [AW-1:0]             idx_dn;

  lanc_ram #(.WIDTH(SW), .DEPTH(TAPS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_in),
    .waddr_i (pos_q),
    .wdata_i (reference_i),
    .re_i    (cmd_i.issue),
    .raddr_i (idx_q),
    .rdata_o (x_rdata)
  );

  lanc_ram #(.WIDTH(SW), .DEPTH(TAPS)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (v3_q),
    .waddr_i (a3_q),
    .wdata_i (w_new),
    .re_i    (cmd_i.issue),
    .raddr_i (tap_q),
    .rdata_o (w_rdata)
  );

  // entries never written read as zero
  assign w1 = wv1_q ? signed'(w_rdata) : '0;
  assign x1 = hv1_q ? signed'(x_rdata) : '0;

  assign ma    = cmd_i.upd ? signed'({2'b00, step_q}) : signed'({w1[SW-1], w1});
  assign mb    = {x1[SW-1], x1};
  assign mul_a = ma * mb;

  // floor shifts drop low bits of the registered products
  assign t1    = signed'(p1_q[PW-1:lanc_pkg::STEP_SHIFT]);
  assign mul_b = err_q * t1;
  assign w_new = w3_q + signed'(p2_q[lanc_pkg::Q_SHIFT+SW-1:lanc_pkg::Q_SHIFT]);

  assign rnd   = acc_q + ACC_W'(1 << (lanc_pkg::Q_SHIFT - 1));
  assign sh    = signed'(rnd[ACC_W-1:lanc_pkg::Q_SHIFT]);
  assign sh_hi = sh[SH_W-1:SW-1];

  always_comb begin
    if ((sh_hi == '0) || (sh_hi == '1)) begin
      est_d = sh[SW-1:0];
    end else if (sh[SH_W-1]) begin
      est_d = {1'b1, {(SW-1){1'b0}}};
    end else begin
      est_d = {1'b0, {(SW-1){1'b1}}};
    end
  end

  assign err_d  = d_q - est_d;
  assign idx_dn = (idx_q == '0) ? AW'(TAPS - 1) : idx_q - AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= lanc_pkg::STEP_RESET;
      pos_q    <= '0;
      tap_q    <= '0;
      idx_q    <= '0;
      hv_q     <= '0;
      wv_q     <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      flag_q   <= 1'b0;
      prev_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        step_q <= cfg_data_i;
      end
      if (cmd_i.load_in) begin
        hv_q[pos_q] <= 1'b1;
      end
      if (cmd_i.start) begin
        tap_q <= '0;
        idx_q <= pos_q;
      end else if (cmd_i.issue) begin
        tap_q <= tap_q + AW'(1);
        idx_q <= idx_dn;
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q & cmd_i.upd;
      if (v3_q) begin
        wv_q[a3_q] <= 1'b1;
      end
      if (cmd_i.finish) begin
        pos_q  <= (pos_q == AW'(TAPS - 1)) ? '0 : pos_q + AW'(1);
        prev_q <= btn_q;
        if (!prev_q && btn_q) begin
          flag_q <= !flag_q;
        end
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      d_q   <= primary_i;
      btn_q <= button_i;
      acc_q <= '0;
    end else if (v2_q && !cmd_i.upd) begin
      acc_q <= acc_q + {{(ACC_W-PW){p1_q[PW-1]}}, p1_q};
    end
    if (cmd_i.issue) begin
      a1_q  <= tap_q;
      wv1_q <= wv_q[tap_q];
      hv1_q <= hv_q[idx_q];
    end
    p1_q <= mul_a[PW-1:0];
    w2_q <= w1;
    a2_q <= a1_q;
    p2_q <= mul_b;
    w3_q <= w2_q;
    a3_q <= a2_q;
    if (cmd_i.est_load) begin
      est_q <= est_d;
      err_q <= err_d;
    end
    if (cmd_i.finish) begin
      oout_q  <= flag_q ? err_q : d_q;
      oerr_q  <= err_q;
      oest_q  <= est_q;
      omode_q <= flag_q;
    end
  end

  assign sts_o.pipe_busy = v1_q | v2_q | v3_q;
  assign sts_o.out_busy  = ovalid_q & ~out_ready_i;

  assign out_valid_o       = ovalid_q;
  assign out_sample_o      = oout_q;
  assign error_sample_o    = oerr_q;
  assign estimate_sample_o = oest_q;
  assign cancel_mode_o     = omode_q;

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> a3_q < AW'(TAPS - 1) || a3_q == AW'(TAPS - 1))
    else $error("weight write outside tap range");

  a_wr_only_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> cmd_i.upd && !cmd_i.load_in)
    else $error("weight write outside update pass");

  a_finish_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(v1_q || v2_q || v3_q))
    else $error("result loaded while update pipeline busy");

endmodule

>>> design/lms_adaptive_noise_canceller_unit.sv
// LMS adaptive noise canceller, Q15 FIR of TAPS taps.
// Input stream (s_axis_*): one beat carries a primary sample, a reference
// noise sample and the raw button level. Output stream (m_axis_*): one beat
// per input with the selected output, the error, the estimate and the mode.
// Config channel (cfg_*): step size in Q1.14, always ready; write only when
// the block is idle.
// Each item runs through one shared read/multiply pipeline twice: a filter
// pass and a weight update pass, each issuing TAPS tap reads, followed by the
// drain of the memory read and multiplier stages. The next item is accepted
// right after the result is moved to the output register, so a new item is
// not taken while the previous one is still being processed.
// The output register holds one finished beat; while the receiver stalls,
// the next item is accepted and processed, and waits before its result load
// until the held beat is taken.
// Reset clears weights and reference history (per-entry valid bits, no
// clearing pass), write position, mode (passthrough), button history, and
// sets the step size to 3280.
module lms_adaptive_noise_canceller_unit #(
  parameter int TAPS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i,     // step_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // primary_sample, reference_sample, button_level
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_sample, error_sample, estimate_sample
  output logic [0:0]  m_axis_tuser    // cancel_mode
);

  lanc_pkg::cmd_t cmd;
  lanc_pkg::sts_t sts;

  logic signed [lanc_pkg::SAMPLE_W-1:0] out_sample, error_sample, estimate_sample;
  logic                                 cancel_mode;

  assign cfg_ready_o = 1'b1;

  lanc_ctrl #(.TAPS(TAPS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lanc_datapath #(.TAPS(TAPS)) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .primary_i         (s_axis_tdata[15:0]),
    .reference_i       (s_axis_tdata[31:16]),
    .button_i          (s_axis_tdata[32]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_sample_o      (out_sample),
    .error_sample_o    (error_sample),
    .estimate_sample_o (estimate_sample),
    .cancel_mode_o     (cancel_mode)
  );

  assign m_axis_tdata = {estimate_sample, error_sample, out_sample};
  assign m_axis_tuser = cancel_mode;

endmodule

>>> sim/tb_lms_adaptive_noise_canceller_unit.sv
module tb_lms_adaptive_noise_canceller_unit;

  localparam int TAPS     = 15;
  localparam int SAMPLE_W = lanc_pkg::SAMPLE_W;
  localparam int STEP_W   = lanc_pkg::STEP_W;

  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] est;
    logic [SAMPLE_W-1:0] err;
    logic [SAMPLE_W-1:0] out;
  } beat_t;

  typedef enum logic {ROW_BEAT, ROW_STEP} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [SAMPLE_W-1:0] primary;
    logic [SAMPLE_W-1:0] reference;
    logic                button;
    logic [STEP_W-1:0]   step;
    logic                known;
    beat_t               want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [STEP_W-1:0]   cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [39:0]         s_axis_tdata;   // primary_sample, reference_sample, button_level
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [47:0]         m_axis_tdata;   // out_sample, error_sample, estimate_sample
  logic [0:0]          m_axis_tuser;   // cancel_mode

  lms_adaptive_noise_canceller_unit #(.TAPS(TAPS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // canceller state mirror
  logic signed [SAMPLE_W-1:0] noise_weights [TAPS];
  logic signed [SAMPLE_W-1:0] ref_hist [TAPS];
  int                         hist_pos;
  logic                       cancel_on;
  logic                       last_button;
  logic [STEP_W-1:0]          step_q;

  beat_t     expected_beats [$];
  stim_row_t stim_table [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req_cnt;
  int fail_count;
  int items_sent;
  int beats_checked;
  int step_writes;
  int cancel_beats;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic beat_t predict_beat(input logic signed [SAMPLE_W-1:0] p,
                                         input logic signed [SAMPLE_W-1:0] r,
                                         input logic b);
    longint                     acc;
    longint                     t;
    int                         idx;
    logic signed [SAMPLE_W-1:0] est;
    logic signed [SAMPLE_W-1:0] err;
    beat_t                      res;
    ref_hist[hist_pos] = r;
    acc = 0;
    for (int k = 0; k < TAPS; k++) begin
      idx = (hist_pos + TAPS - k) % TAPS;
      acc += longint'(noise_weights[k]) * longint'(ref_hist[idx]);
    end
    acc = (acc + 64'sd16384) >>> lanc_pkg::Q_SHIFT;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    est = acc[SAMPLE_W-1:0];
    err = p - est;
    // weight update uses the error just formed, newest reference first
    for (int k = 0; k < TAPS; k++) begin
      idx = (hist_pos + TAPS - k) % TAPS;
      t = (longint'(step_q) * longint'(ref_hist[idx])) >>> lanc_pkg::STEP_SHIFT;
      t = (longint'(err) * t) >>> lanc_pkg::Q_SHIFT;
      noise_weights[k] = noise_weights[k] + t[SAMPLE_W-1:0];
    end
    hist_pos = (hist_pos + 1) % TAPS;
    res.mode = cancel_on;
    res.est  = est;
    res.err  = err;
    res.out  = cancel_on ? err : p;
    // mode flips only on a rising button edge, after the output is formed
    if (!last_button && b) cancel_on = ~cancel_on;
    last_button = b;
    return res;
  endfunction

  function automatic void add_beat(input logic [SAMPLE_W-1:0] p, input logic [SAMPLE_W-1:0] r,
                                   input logic b);
    stim_row_t row;
    row.kind = ROW_BEAT;
    row.primary = p;
    row.reference = r;
    row.button = b;
    row.step = '0;
    row.known = 1'b0;
    row.want = '0;
    stim_table.push_back(row);
  endfunction

  function automatic void add_known(input logic [SAMPLE_W-1:0] p, input logic [SAMPLE_W-1:0] r,
                                    input logic b, input beat_t want);
    add_beat(p, r, b);
    stim_table[$].known = 1'b1;
    stim_table[$].want = want;
  endfunction

  function automatic void add_step(input logic [STEP_W-1:0] s);
    stim_row_t row;
    row.kind = ROW_STEP;
    row.primary = '0;
    row.reference = '0;
    row.button = 1'b0;
    row.step = s;
    row.known = 1'b0;
    row.want = '0;
    stim_table.push_back(row);
  endfunction

  task automatic offer_beat(input logic [SAMPLE_W-1:0] p, input logic [SAMPLE_W-1:0] r,
                            input logic b, output beat_t pred);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, b, r, p};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_beat(p, r, b);
    items_sent++;
  endtask

  // stop offering and wait for the block to hand back every result
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_beats.size() != 0);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] v);
    drain_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    step_q = v;
    step_writes++;
  endtask

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    int    hold_left;
    int    hold_done;
    beat_t got;
    beat_t want;
    hold_left = 0;
    hold_done = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser[0], m_axis_tdata[47:32], m_axis_tdata[31:16], m_axis_tdata[15:0]};
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected output beat out=%h err=%h est=%h mode=%b", $time,
                   got.out, got.err, got.est, got.mode);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            $display("%0t: expected out=%h err=%h est=%h m=%b, got out=%h err=%h est=%h m=%b",
                     $time, want.out, want.err, want.est, want.mode,
                     got.out, got.err, got.est, got.mode);
            fail_count++;
          end
          beats_checked++;
          if (got.mode) cancel_beats++;
        end
      end
      if (hold_done != hold_req_cnt) begin
        hold_done++;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    beat_t             pred;
    stim_row_t         row;
    logic [15:0]       p;
    logic [15:0]       r;
    logic [15:0]       prev_r;
    logic              btn;
    int                mix;
    logic [STEP_W-1:0] new_step;

    fail_count = 0;
    items_sent = 0;
    beats_checked = 0;
    step_writes = 0;
    cancel_beats = 0;
    hold_req_cnt = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < TAPS; k++) begin
      noise_weights[k] = '0;
      ref_hist[k] = '0;
    end
    hist_pos = 0;
    cancel_on = 1'b0;
    last_button = 1'b0;
    step_q = lanc_pkg::STEP_RESET;

    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part; the first two rows follow from all-zero weights
    add_known(16'h7fff, 16'h8000, 1'b0, '{mode: 1'b0, est: 16'h0000, err: 16'h7fff,
                                          out: 16'h7fff});
    add_known(16'h8000, 16'h0000, 1'b1, '{mode: 1'b0, est: 16'h0000, err: 16'h8000,
                                          out: 16'h8000});
    add_beat(16'h0000, 16'h0000, 1'b1);     // button held, no toggle
    add_beat(16'h8000, 16'h8000, 1'b0);
    add_beat(16'd12345, 16'hffff, 1'b1);    // toggle back to passthrough
    add_beat(16'hffff, 16'h7fff, 1'b1);
    add_step({STEP_W{1'b1}});
    // max step with full-scale inputs: weights wrap and the estimate saturates
    for (int i = 0; i < 8; i++)
      add_beat(i[0] ? 16'h8000 : 16'h7fff, i[1] ? 16'h8000 : 16'h7fff, i[2]);
    add_step('0);
    add_beat(16'h8000, 16'h0001, 1'b0);
    add_beat(16'h7fff, 16'hffff, 1'b0);
    add_beat(16'h0000, 16'h8000, 1'b1);
    add_step(15'd1);
    add_beat(16'hfffe, 16'h8000, 1'b0);
    add_beat(16'h7fff, 16'h7fff, 1'b1);
    add_step(lanc_pkg::STEP_RESET);

    send_idle_pct = 20;
    recv_idle_pct = 20;
    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.kind == ROW_STEP) begin
        write_step(row.step);
      end else begin
        offer_beat(row.primary, row.reference, row.button, pred);
        expected_beats.push_back(row.known ? row.want : pred);
      end
    end

    // random part: mostly a reference leaking into the primary, some raw noise
    prev_r = '0;
    btn = 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 30; recv_idle_pct = 69; end
        1: begin send_idle_pct = 69; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < 350; n++) begin
        if (n % 70 == 0) begin
          case ($urandom_range(0, 4))
            0: new_step = {STEP_W{1'b1}};
            1: new_step = '0;
            2: new_step = STEP_W'($urandom_range(0, 32767));
            default: new_step = STEP_W'($urandom_range(100, 6000));
          endcase
          write_step(new_step);
        end
        if (n == 150 && ph != 1) hold_req_cnt++;
        mix = $urandom_range(0, 99);
        r = 16'($urandom);
        if (mix < 5) r = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        if (mix < 75)
          p = 16'(int'($signed(r) >>> 1) + int'($signed(prev_r) >>> 2)
                  + int'($urandom_range(0, 2047)) - 1024);
        else if (mix < 90)
          p = 16'($urandom);
        else
          p = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        if ($urandom_range(0, 99) < 6) btn = ~btn;
        prev_r = r;
        offer_beat(p, r, btn, pred);
        expected_beats.push_back(pred);
      end
    end

    drain_block();
    repeat (60) @(posedge clk_i);

    $display("Covered %0d input beats and %0d output beats, %0d in cancelling mode,",
             items_sent, beats_checked, cancel_beats);
    $display("across %0d step-size writes including zero, one and full scale.", step_writes);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
